### rtl/dept_pkg.sv
`timescale 1ns / 1ps

package dept_pkg;

   localparam int COORD_BITS = 16;
   localparam int KEY_BITS = COORD_BITS + 2;
   localparam int NUM_DIRS = 8;
   localparam int NUM_FOUR = 4;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [1:0] MODE_EIGHT = 2'd0;
   localparam logic [1:0] MODE_AXIS = 2'd1;
   localparam logic [1:0] MODE_CORNER = 2'd2;

   localparam logic REG_DIRECTION_MODE = 1'b0;

   typedef enum logic [2:0] {
      DIR_MIN_X = 3'd0,
      DIR_NORTH_WEST = 3'd1,
      DIR_MAX_Y = 3'd2,
      DIR_NORTH_EAST = 3'd3,
      DIR_MAX_X = 3'd4,
      DIR_SOUTH_EAST = 3'd5,
      DIR_MIN_Y = 3'd6,
      DIR_SOUTH_WEST = 3'd7
   } dir_type;

   localparam dir_type AXIS_ORDER [NUM_FOUR] = '{DIR_MIN_X, DIR_MAX_Y, DIR_MAX_X, DIR_MIN_Y};
   localparam dir_type CORNER_ORDER [NUM_FOUR] =
      '{DIR_NORTH_EAST, DIR_SOUTH_EAST, DIR_SOUTH_WEST, DIR_NORTH_WEST};

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [KEY_BITS-1:0] key_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } slot_pair_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      logic set_end;
   } req_point_type;

   typedef struct packed {
      coord_type extreme_x;
      coord_type extreme_y;
      logic [2:0] slot_index;
      logic run_end;
   } rsp_point_type;

   typedef struct packed {
      logic load;
      logic [1:0] mode;
      slot_pair_type [NUM_DIRS-1:0] pts;
   } emit_load_type;

endpackage

### rtl/directional_extreme_point_tracker_core.sv
`timescale 1ns / 1ps

// Tracks the extreme points of a stream of integer points in up to eight directions.
// Points enter on the req channel, one transaction per point; set_end marks the last
// point of a set. The first point of a set seeds all eight slots, and later points
// replace a slot only when strictly better, so ties keep the earliest point.
// When the last point of a set has been absorbed, the slots chosen by direction_mode
// leave on the rsp channel in order, one transaction each, with duplicates of the
// previous result dropped; the final one carries run_end.
// A point is taken every cycle unless a set_end point waits in the input register.
// Results leave one per cycle, up to eight per set, while the receiver does not stall.
// The result buffer holds one set, so a set_end point waits in the input register
// while the previous run is still being sent; points that do not end a set flow on.
// When the receiver stalls, the current result holds. Reset clears the pipeline and
// sets the mode to eight directions. Write direction_mode at byte address 0 through
// the csr port only while the block is idle.
module directional_extreme_point_tracker_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  dept_pkg::req_point_type req_point,
   output logic rsp_valid,
   input  logic rsp_stall,
   output dept_pkg::rsp_point_type rsp_point,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [dept_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [dept_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [dept_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic csr_pready
);

   logic [1:0] mode_ff;
   logic [1:0] mode_in;
   logic csr_index;
   logic csr_write;
   logic in_valid_ff;
   logic in_valid_in;
   dept_pkg::req_point_type in_point_ff;
   logic req_accept;
   logic advance;
   logic step;
   logic buf_free;
   dept_pkg::slot_pair_type [dept_pkg::NUM_DIRS-1:0] slot_next;
   dept_pkg::emit_load_type load_req;

   assign csr_pready = 1'b1;
   assign csr_index = csr_paddr[dept_pkg::CSR_ADDR_BITS-1];
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                      (csr_index == dept_pkg::REG_DIRECTION_MODE);
   assign mode_in = csr_write ? csr_pwdata[1:0] : mode_ff;
   assign csr_prdata = (csr_index == dept_pkg::REG_DIRECTION_MODE) ?
                       dept_pkg::CSR_DATA_BITS'(mode_ff) : '0;

   assign advance = !in_point_ff.set_end || buf_free;
   assign step = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= dept_pkg::MODE_EIGHT;
         in_valid_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_point_ff <= req_point;
      end
   end

   dept_slot_bank u_slot_bank (
      .clock(clock),
      .reset(reset),
      .step(step),
      .point(in_point_ff),
      .slot_next(slot_next)
   );

   assign load_req.load = step && in_point_ff.set_end;
   assign load_req.mode = mode_ff;
   assign load_req.pts = slot_next;

   dept_emit_queue u_emit_queue (
      .clock(clock),
      .reset(reset),
      .load_req(load_req),
      .buf_free(buf_free),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_point(rsp_point)
   );

endmodule

### rtl/dept_slot_bank.sv
`timescale 1ns / 1ps

module dept_slot_bank (
   input  logic clock,
   input  logic reset,
   input  logic step,
   input  dept_pkg::req_point_type point,
   output dept_pkg::slot_pair_type [dept_pkg::NUM_DIRS-1:0] slot_next
);

   dept_pkg::slot_pair_type [dept_pkg::NUM_DIRS-1:0] slot_ff;
   logic awaiting_first_ff;
   logic awaiting_first_in;

   function automatic dept_pkg::key_type dir_key(input dept_pkg::dir_type dir,
                                                 input dept_pkg::coord_type x,
                                                 input dept_pkg::coord_type y);
      dept_pkg::key_type xe;
      dept_pkg::key_type ye;
      xe = dept_pkg::KEY_BITS'(x);
      ye = dept_pkg::KEY_BITS'(y);
      case (dir)
         dept_pkg::DIR_MIN_X: dir_key = -xe;
         dept_pkg::DIR_NORTH_WEST: dir_key = ye - xe;
         dept_pkg::DIR_MAX_Y: dir_key = ye;
         dept_pkg::DIR_NORTH_EAST: dir_key = xe + ye;
         dept_pkg::DIR_MAX_X: dir_key = xe;
         dept_pkg::DIR_SOUTH_EAST: dir_key = xe - ye;
         dept_pkg::DIR_MIN_Y: dir_key = -ye;
         default: dir_key = -(xe + ye);
      endcase
   endfunction

   for (genvar d = 0; d < dept_pkg::NUM_DIRS; d++) begin : g_dir
      logic better;
      assign better = dir_key(dept_pkg::dir_type'(d), point.point_x, point.point_y) >
                      dir_key(dept_pkg::dir_type'(d), slot_ff[d].x, slot_ff[d].y);
      assign slot_next[d] = (awaiting_first_ff || better) ?
                            {point.point_x, point.point_y} : slot_ff[d];
   end

   assign awaiting_first_in = step ? point.set_end : awaiting_first_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_first_ff <= 1'b1;
      end else begin
         awaiting_first_ff <= awaiting_first_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         slot_ff <= slot_next;
      end
   end

endmodule

### rtl/dept_emit_queue.sv
`timescale 1ns / 1ps

module dept_emit_queue (
   input  logic clock,
   input  logic reset,
   input  dept_pkg::emit_load_type load_req,
   output logic buf_free,
   output logic rsp_valid,
   input  logic rsp_stall,
   output dept_pkg::rsp_point_type rsp_point
);

   dept_pkg::slot_pair_type [dept_pkg::NUM_DIRS-1:0] ordered_ff;
   dept_pkg::slot_pair_type [dept_pkg::NUM_DIRS-1:0] ordered_in;
   logic [dept_pkg::NUM_DIRS-1:0] pending_ff;
   logic [dept_pkg::NUM_DIRS-1:0] pending_in;
   logic [dept_pkg::NUM_DIRS-1:0] keep;
   logic [dept_pkg::NUM_DIRS-1:0] low_bit;
   logic [dept_pkg::NUM_DIRS-1:0] rest;
   logic [2:0] sel;
   logic found;
   logic rsp_fire;
   logic four_slots;

   always_comb begin
      four_slots = 1'b0;
      ordered_in = load_req.pts;
      case (load_req.mode)
         dept_pkg::MODE_AXIS: begin
            four_slots = 1'b1;
            for (int i = 0; i < dept_pkg::NUM_FOUR; i++) begin
               ordered_in[i] = load_req.pts[dept_pkg::AXIS_ORDER[i]];
            end
         end
         dept_pkg::MODE_CORNER: begin
            four_slots = 1'b1;
            for (int i = 0; i < dept_pkg::NUM_FOUR; i++) begin
               ordered_in[i] = load_req.pts[dept_pkg::CORNER_ORDER[i]];
            end
         end
         default: begin
            four_slots = 1'b0;
         end
      endcase
      keep[0] = 1'b1;
      for (int i = 1; i < dept_pkg::NUM_DIRS; i++) begin
         keep[i] = (ordered_in[i] != ordered_in[i-1]) &&
                   !(four_slots && (i >= dept_pkg::NUM_FOUR));
      end
   end

   always_comb begin
      sel = '0;
      found = 1'b0;
      for (int i = 0; i < dept_pkg::NUM_DIRS; i++) begin
         if (pending_ff[i] && !found) begin
            sel = 3'(i);
            found = 1'b1;
         end
      end
      low_bit = dept_pkg::NUM_DIRS'(1) << sel;
      rest = pending_ff & ~low_bit;
   end

   assign rsp_valid = |pending_ff;
   assign rsp_fire = rsp_valid && !rsp_stall;
   assign buf_free = !rsp_valid || (rsp_fire && (rest == '0));

   assign rsp_point.extreme_x = ordered_ff[sel].x;
   assign rsp_point.extreme_y = ordered_ff[sel].y;
   assign rsp_point.slot_index = sel;
   assign rsp_point.run_end = (rest == '0);

   always_comb begin
      if (load_req.load) begin
         pending_in = keep;
      end else if (rsp_fire) begin
         pending_in = rest;
      end else begin
         pending_in = pending_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_req.load) begin
         ordered_ff <= ordered_in;
      end
   end

endmodule

### dv/dept_checker.sv
`timescale 1ns / 1ps

module dept_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_stall,
   input  dept_pkg::req_point_type req_point,
   input  logic rsp_valid,
   input  logic rsp_stall,
   input  dept_pkg::rsp_point_type rsp_point,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic csr_pready,
   input  logic [dept_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [dept_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output int fail_count,
   output int pending_count
);

   import dept_pkg::*;

   localparam logic [CSR_ADDR_BITS-1:0] DIRECTION_MODE_ADDR =
      CSR_ADDR_BITS'({REG_DIRECTION_MODE, 2'b00});

   logic [1:0] active_mode;
   logic awaiting_first;
   coord_type slot_x [NUM_DIRS];
   coord_type slot_y [NUM_DIRS];
   rsp_point_type expected_extremes [$];

   task automatic report_mismatch(string what);
      $display("%0t: mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   function automatic int direction_score(dir_type d, int x, int y);
      case (d)
         DIR_MIN_X: return -x;
         DIR_NORTH_WEST: return y - x;
         DIR_MAX_Y: return y;
         DIR_NORTH_EAST: return x + y;
         DIR_MAX_X: return x;
         DIR_SOUTH_EAST: return x - y;
         DIR_MIN_Y: return -y;
         default: return -(x + y);
      endcase
   endfunction

   task automatic absorb_point(req_point_type p);
      dir_type order [NUM_DIRS];
      int count;
      rsp_point_type emitted [$];
      rsp_point_type r;
      coord_type px;
      coord_type py;
      dir_type d;
      px = '0;
      py = '0;
      for (int i = 0; i < NUM_DIRS; i++) begin
         d = dir_type'(i);
         if (awaiting_first || direction_score(d, p.point_x, p.point_y) >
             direction_score(d, slot_x[i], slot_y[i])) begin
            slot_x[i] = p.point_x;
            slot_y[i] = p.point_y;
         end
      end
      awaiting_first = 1'b0;
      if (!p.set_end) return;
      case (active_mode)
         MODE_AXIS: begin
            count = NUM_FOUR;
            for (int i = 0; i < NUM_FOUR; i++) order[i] = AXIS_ORDER[i];
         end
         MODE_CORNER: begin
            count = NUM_FOUR;
            for (int i = 0; i < NUM_FOUR; i++) order[i] = CORNER_ORDER[i];
         end
         default: begin
            count = NUM_DIRS;
            for (int i = 0; i < NUM_DIRS; i++) order[i] = dir_type'(i);
         end
      endcase
      for (int i = 0; i < count; i++) begin
         if (emitted.size() > 0 && slot_x[order[i]] == px && slot_y[order[i]] == py) continue;
         r.extreme_x = slot_x[order[i]];
         r.extreme_y = slot_y[order[i]];
         r.slot_index = 3'(i);
         r.run_end = 1'b0;
         emitted = {emitted, r};
         px = r.extreme_x;
         py = r.extreme_y;
      end
      emitted[emitted.size()-1].run_end = 1'b1;
      foreach (emitted[i]) expected_extremes = {expected_extremes, emitted[i]};
      awaiting_first = 1'b1;
   endtask

   task automatic check_extreme(rsp_point_type got);
      rsp_point_type want;
      if (expected_extremes.size() == 0) begin
         report_mismatch($sformatf("unexpected result x=%0d y=%0d slot=%0d end=%0b",
            got.extreme_x, got.extreme_y, got.slot_index, got.run_end));
         return;
      end
      want = expected_extremes.pop_front();
      if (got.extreme_x !== want.extreme_x)
         report_mismatch($sformatf("extreme_x %0d, expected %0d", got.extreme_x, want.extreme_x));
      if (got.extreme_y !== want.extreme_y)
         report_mismatch($sformatf("extreme_y %0d, expected %0d", got.extreme_y, want.extreme_y));
      if (got.slot_index !== want.slot_index)
         report_mismatch($sformatf("slot_index %0d, expected %0d", got.slot_index,
            want.slot_index));
      if (got.run_end !== want.run_end)
         report_mismatch($sformatf("run_end %0b, expected %0b", got.run_end, want.run_end));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         active_mode = MODE_EIGHT;
         awaiting_first = 1'b1;
         expected_extremes.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == DIRECTION_MODE_ADDR)
            active_mode = csr_pwdata[1:0];
         if (rsp_valid && !rsp_stall) check_extreme(rsp_point);
         if (req_valid && !req_stall) absorb_point(req_point);
      end
      pending_count = expected_extremes.size();
   end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;

   import dept_pkg::*;

   localparam logic [CSR_ADDR_BITS-1:0] DIRECTION_MODE_ADDR =
      CSR_ADDR_BITS'({REG_DIRECTION_MODE, 2'b00});
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 8;
   localparam int ITEMS_PER_SETTING = 27;
   localparam int IDLE_PCT [4] = '{0, 74, 0, 37};
   localparam int STALL_PCT [4] = '{0, 0, 74, 37};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_point_type req_point = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_point_type rsp_point;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   int fail_count;
   int pending_count;
   int idle_pct = 0;
   int stall_pct = 0;
   coord_type last_x = '0;
   coord_type last_y = '0;

   directional_extreme_point_tracker_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_point(req_point),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_point(rsp_point),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   dept_checker checker_inst (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_point(req_point),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_point(rsp_point),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   task automatic send_point(coord_type x, coord_type y, logic set_end);
      while ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_point <= '{point_x: x, point_y: y, set_end: set_end};
      last_x = x;
      last_y = y;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_direction_mode(logic [1:0] mode);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= DIRECTION_MODE_ADDR;
      csr_pwdata <= CSR_DATA_BITS'(mode);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   function automatic coord_type make_coord(int style, coord_type previous);
      case (style)
         0: return coord_type'($urandom);
         1: return coord_type'($signed($urandom_range(0, 6)) - 3);
         2: begin
            case ($urandom_range(0, 3))
               0: return coord_type'(-32768);
               1: return coord_type'(32767);
               2: return coord_type'(0);
               default: return coord_type'(-1);
            endcase
         end
         default: return previous;
      endcase
   endfunction

   task automatic send_random_set(inout int sent);
      int length;
      int pick;
      int style;
      coord_type x;
      coord_type y;
      length = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 16);
      pick = $urandom_range(0, 99);
      style = (pick < 60) ? 0 : (pick < 85) ? 1 : (pick < 95) ? 2 : 3;
      for (int i = 0; i < length; i++) begin
         if (style == 3 && $urandom_range(0, 1) == 0) begin
            x = last_x;
            y = last_y;
         end else begin
            x = make_coord(style == 3 ? 0 : style, last_x);
            y = make_coord(style == 3 ? 0 : style, last_y);
         end
         send_point(x, y, i == length - 1);
         sent++;
      end
   endtask

   initial begin
      int sent;
      logic [1:0] mode;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_point(32767, -32768, 1'b1);
      send_point(-32768, -32768, 1'b0);
      send_point(32767, 32767, 1'b0);
      send_point(-32768, 32767, 1'b0);
      send_point(32767, -32768, 1'b1);
      send_point(2, 2, 1'b0);
      send_point(2, 2, 1'b0);
      send_point(-1, 3, 1'b0);
      send_point(3, -1, 1'b0);
      send_point(-1, 3, 1'b1);
      send_point(7, 7, 1'b0);
      send_point(7, 7, 1'b1);
      send_point(1, 2, 1'b0);
      wait_idle();
      write_direction_mode(MODE_AXIS);
      send_point(3, -4, 1'b0);
      send_point(-5, 6, 1'b1);
      wait_idle();
      write_direction_mode(MODE_CORNER);
      send_point(0, 0, 1'b0);
      send_point(4, 1, 1'b0);
      send_point(-2, -3, 1'b1);
      wait_idle();
      write_direction_mode(MODE_UNUSED);
      send_point(10, -10, 1'b0);
      send_point(-10, 10, 1'b1);
      wait_idle();

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = IDLE_PCT[phase];
         stall_pct = STALL_PCT[phase];
         for (int setting = 0; setting < 4; setting++) begin
            mode = 2'(phase + setting);
            write_direction_mode(mode);
            sent = 0;
            while (sent < ITEMS_PER_SETTING) send_random_set(sent);
            wait_idle();
         end
      end

      if (fail_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### files.f
rtl/dept_pkg.sv
rtl/dept_slot_bank.sv
rtl/dept_emit_queue.sv
rtl/directional_extreme_point_tracker_core.sv
dv/dept_checker.sv
dv/tb.sv
